FILE: hdl/hdmu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdmu_pkg
// Types, constants and neighbor helper for the hex distance map updater.
// ----------------------------------------------------------------------------
package hdmu_pkg;

    localparam int MAP_BITS        = 8;
    localparam int RING_DEPTH      = 4096;
    localparam int UNEXPLORED_CODE = 63;

    localparam int DIST_W   = 6;
    localparam int CELL_W   = 2 * MAP_BITS;
    localparam int CELLS    = 1 << CELL_W;
    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int PADDR_W  = 3;
    localparam int NB_COUNT = 6;

    localparam logic [DIST_W-1:0] UNEX      = DIST_W'(UNEXPLORED_CODE);
    localparam logic [DIST_W-1:0] UNEX_M1   = DIST_W'(UNEXPLORED_CODE - 1);
    localparam logic [DIST_W-1:0] DIST_MIN  = DIST_W'(2);
    localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(62);
    localparam logic [DIST_W-1:0] DIST_RST  = DIST_W'(60);

    localparam logic [1:0] REQ_SET        = 2'd0;
    localparam logic [1:0] REQ_CLEAR      = 2'd1;
    localparam logic [1:0] REQ_CLEAR_FAST = 2'd2;
    localparam logic [1:0] REQ_EXPLORE    = 2'd3;

    localparam logic [PADDR_W-1:0] ADDR_MAX_DIST = PADDR_W'(0);

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        cell_x;
        logic [7:0]        cell_y;
        logic [DIST_W-1:0] cell_value;
    } req_t;

    typedef struct packed {
        logic changed;
        logic queue_overflow;
    } rsp_t;

    typedef struct packed {
        logic              push;
        logic [CELL_W-1:0] push_data;
        logic              pop;
        logic              clr_ovf;
    } ring_ctl_t;

    typedef struct packed {
        logic              empty;
        logic [CELL_W-1:0] data;
        logic              ovf;
    } ring_sts_t;

    typedef struct packed {
        logic              ok;
        logic [CELL_W-1:0] idx;
    } nb_t;

    function automatic nb_t hdmu_nb(input logic [MAP_BITS-1:0] x,
                                    input logic [MAP_BITS-1:0] y,
                                    input logic [2:0] k);
        nb_t              r;
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic [MAP_BITS:0] nx;
        logic [MAP_BITS:0] ny;
        dx = 2'sd0;
        dy = 2'sd0;
        r.ok = 1'b1;
        case (k)
            3'd0: begin dx = y[0] ? -2'sd1 : -2'sd1; dy =  2'sd0; end
            3'd1: begin dx = y[0] ?  2'sd0 : -2'sd1; dy = -2'sd1; end
            3'd2: begin dx = y[0] ?  2'sd1 :  2'sd0; dy = -2'sd1; end
            3'd3: begin dx =  2'sd1;                 dy =  2'sd0; end
            3'd4: begin dx = y[0] ?  2'sd1 :  2'sd0; dy =  2'sd1; end
            3'd5: begin dx = y[0] ?  2'sd0 : -2'sd1; dy =  2'sd1; end
            default: r.ok = 1'b0;
        endcase
        nx = {1'b0, x} + {{(MAP_BITS-1){dx[1]}}, dx};
        ny = {1'b0, y} + {{(MAP_BITS-1){dy[1]}}, dy};
        r.ok  = r.ok & ~nx[MAP_BITS] & ~ny[MAP_BITS];
        r.idx = {ny[MAP_BITS-1:0], nx[MAP_BITS-1:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/hdmu_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdmu_ring
// Work ring of cell indices: one push and one pop per cycle, registered read.
// A push into a full ring is dropped and sets the overflow flag.
// ----------------------------------------------------------------------------
module hdmu_ring (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hdmu_pkg::ring_ctl_t ctl,
    output hdmu_pkg::ring_sts_t      sts
);
    import hdmu_pkg::*;

    logic [CELL_W-1:0]  ring_mem [RING_DEPTH];
    logic [RING_AW-1:0] head_reg;
    logic [RING_AW-1:0] tail_reg;
    logic [RING_AW-1:0] tail_inc;
    logic               ovf_reg;
    logic [CELL_W-1:0]  data_reg;
    logic               full;

    assign tail_inc = tail_reg + RING_AW'(1);
    assign full     = (tail_inc == head_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.push && !full)
        begin
            ring_mem[tail_reg] <= ctl.push_data;
        end
        if (ctl.pop)
        begin
            data_reg <= ring_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clr_ovf)
            begin
                ovf_reg <= 1'b0;
            end
            if (ctl.push)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    tail_reg <= tail_inc;
                end
            end
            if (ctl.pop)
            begin
                head_reg <= head_reg + RING_AW'(1);
            end
        end
    end

    assign sts.empty = (head_reg == tail_reg);
    assign sts.data  = data_reg;
    assign sts.ovf   = ovf_reg;

endmodule
`default_nettype wire

FILE: hdl/hex_distance_map_updater.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_distance_map_updater
// Obstacle distance map on an offset-row hex grid with wavefront updates.
//
// Requests arrive on req/req_valid/req_stall, one beat per request; each
// request returns exactly one beat on rsp/rsp_valid/rsp_stall. The block
// works on one request at a time: req_stall is low only when idle.
// A request that queues nothing steps through target read, target update,
// ring check and evaluate; a set request queuing the target's neighbors
// adds a push step for each neighbor, and each popped ring entry adds pop,
// ring read, cell read, neighbor reads over the single read port of the
// cell memory, evaluate and pushes. Worst case depends on how far the
// wavefront spreads. After reset the cell memory is swept to the unexplored
// code, one cell per cycle over all 65536 cells, with req_stall high.
// Register writes over the APB port are taken at any time and should only
// be done while idle. A finished beat waits in an output register while
// rsp_stall is high; the next request can be taken meanwhile and waits at
// its end if the register is still full.
// ----------------------------------------------------------------------------
module hex_distance_map_updater (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire hdmu_pkg::req_t                  req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output hdmu_pkg::rsp_t                       rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hdmu_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import hdmu_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_TGT_RD   = 10'b0000000100,
        S_TGT      = 10'b0000001000,
        S_PUSHN    = 10'b0000010000,
        S_POP      = 10'b0000100000,
        S_POP_WAIT = 10'b0001000000,
        S_CELL     = 10'b0010000000,
        S_SCAN     = 10'b0100000000,
        S_EVAL     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIST_W-1:0]   cells [CELLS];
    logic [DIST_W-1:0]   cell_rdata_reg;
    logic [CELL_W-1:0]   cell_raddr;
    logic                cell_we;
    logic [CELL_W-1:0]   cell_waddr;
    logic [DIST_W-1:0]   cell_wdata;

    logic [CELL_W-1:0]   clr_cnt_reg;
    logic [DIST_W-1:0]   max_dist_reg;
    logic [DIST_W-1:0]   lim;
    logic [MAP_BITS-1:0] cur_x_reg, cur_x_next;
    logic [MAP_BITS-1:0] cur_y_reg, cur_y_next;
    logic [2:0]          k_reg, k_next;
    req_t                req_reg;
    logic [DIST_W-1:0]   old_reg;
    logic [DIST_W-1:0]   nval_reg [NB_COUNT];
    logic                push_all_reg, push_all_next;
    logic                changed_reg, changed_next;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    logic                done;
    logic                in_map;
    logic                accept;
    logic                cfg_wr;
    nb_t                 nb;
    logic [CELL_W-1:0]   cur_idx;
    logic [DIST_W-1:0]   m_min;
    logic [DIST_W-1:0]   m_new;
    ring_ctl_t           ring_ctl;
    ring_sts_t           ring_sts;

    hdmu_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .sts   (ring_sts)
    );

    assign pready = 1'b1;
    assign prdata = {26'd0, max_dist_reg};
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_DIST);

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign in_map    = ((16'(req.cell_x) >> MAP_BITS) == 16'd0) &&
                       ((16'(req.cell_y) >> MAP_BITS) == 16'd0);

    assign lim = (max_dist_reg < DIST_MIN) ? DIST_MIN :
                 (max_dist_reg > DIST_MAX) ? DIST_MAX : max_dist_reg;

    assign cur_idx = {cur_y_reg, cur_x_reg};
    assign nb      = hdmu_nb(cur_x_reg, cur_y_reg, k_reg);

    always_comb
    begin
        nb_t e;
        m_min = UNEX_M1;
        for (int i = 0; i < NB_COUNT; i++)
        begin
            e = hdmu_nb(cur_x_reg, cur_y_reg, 3'(i));
            if (e.ok && (nval_reg[i] < m_min))
            begin
                m_min = nval_reg[i];
            end
        end
        m_new = m_min + DIST_W'(1);
        if (m_new == DIST_W'(1))
        begin
            m_new = DIST_MIN;
        end
        if (m_new > lim)
        begin
            m_new = lim;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        k_next        = k_reg;
        push_all_next = push_all_reg;
        changed_next  = changed_reg;
        done          = 1'b0;
        cell_raddr    = cur_idx;
        cell_we       = 1'b0;
        cell_waddr    = cur_idx;
        cell_wdata    = UNEX;
        ring_ctl      = '0;
        ring_ctl.push_data = cur_idx;

        unique case (state_reg)
            S_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_cnt_reg;
                if (clr_cnt_reg == CELL_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    ring_ctl.clr_ovf = 1'b1;
                    changed_next     = 1'b0;
                    cur_x_next       = MAP_BITS'(req.cell_x);
                    cur_y_next       = MAP_BITS'(req.cell_y);
                    state_next       = in_map ? S_TGT_RD : S_EVAL;
                    k_next           = in_map ? 3'd0 : 3'd7;
                end
            end
            S_TGT_RD:
            begin
                state_next = S_TGT;
            end
            S_TGT:
            begin
                state_next = S_POP;
                unique case (req_reg.req_type)
                    REQ_SET:
                    begin
                        if (cell_rdata_reg != req_reg.cell_value)
                        begin
                            changed_next  = (cell_rdata_reg > DIST_W'(1));
                            cell_we       = 1'b1;
                            cell_wdata    = req_reg.cell_value;
                            push_all_next = 1'b1;
                            k_next        = 3'd0;
                            state_next    = S_PUSHN;
                        end
                    end
                    REQ_CLEAR, REQ_CLEAR_FAST:
                    begin
                        if (cell_rdata_reg >= req_reg.cell_value)
                        begin
                            changed_next  = 1'b1;
                            cell_we       = 1'b1;
                            cell_wdata    = UNEX_M1;
                            ring_ctl.push = (req_reg.req_type == REQ_CLEAR);
                        end
                    end
                    REQ_EXPLORE:
                    begin
                        if (cell_rdata_reg == UNEX)
                        begin
                            changed_next  = 1'b1;
                            ring_ctl.push = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_PUSHN:
            begin
                ring_ctl.push_data = nb.idx;
                ring_ctl.push = nb.ok && (push_all_reg || (nval_reg[k_reg] != UNEX));
                k_next = k_reg + 3'd1;
                if (k_reg == 3'(NB_COUNT - 1))
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (ring_sts.empty)
                begin
                    k_next     = 3'd7;
                    state_next = S_EVAL;
                end
                else
                begin
                    ring_ctl.pop = 1'b1;
                    state_next   = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                cell_raddr = ring_sts.data;
                cur_x_next = ring_sts.data[MAP_BITS-1:0];
                cur_y_next = ring_sts.data[CELL_W-1:MAP_BITS];
                state_next = S_CELL;
            end
            S_CELL:
            begin
                k_next     = 3'd0;
                state_next = (cell_rdata_reg <= DIST_W'(1)) ? S_POP : S_SCAN;
            end
            S_SCAN:
            begin
                cell_raddr = nb.idx;
                k_next     = k_reg + 3'd1;
                if (k_reg == 3'(NB_COUNT))
                begin
                    k_next     = 3'd0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (k_reg == 3'd7)
                begin
                    // request finished; wait for a free output register
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        done       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (m_new != old_reg)
                begin
                    cell_we       = 1'b1;
                    cell_wdata    = m_new;
                    push_all_next = 1'b0;
                    k_next        = 3'd0;
                    state_next    = S_PUSHN;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cells[cell_waddr] <= cell_wdata;
        end
        cell_rdata_reg <= cells[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == S_CELL)
        begin
            old_reg <= cell_rdata_reg;
        end
        if ((state_reg == S_SCAN) && (k_reg != 3'd0))
        begin
            nval_reg[k_reg - 3'd1] <= cell_rdata_reg;
        end
        if (done)
        begin
            rsp_reg.changed        <= changed_reg;
            rsp_reg.queue_overflow <= ring_sts.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            max_dist_reg  <= DIST_RST;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            k_reg         <= '0;
            push_all_reg  <= 1'b0;
            changed_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            k_reg        <= k_next;
            push_all_reg <= push_all_next;
            changed_reg  <= changed_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CELL_W'(1);
            end
            if (cfg_wr)
            begin
                max_dist_reg <= pwdata[DIST_W-1:0];
            end
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

FILE: hdl/hdmu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdmu_checker
// Port-level checks for the hex distance map updater, bound to the top.
// ----------------------------------------------------------------------------
module hdmu_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_stall,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_stall,
    input wire hdmu_pkg::rsp_t               rsp,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite,
    input wire logic [hdmu_pkg::PADDR_W-1:0] paddr,
    input wire logic [31:0]                  pwdata,
    input wire logic [31:0]                  prdata,
    input wire logic                         pready
);
    import hdmu_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr == ADDR_MAX_DIST)
        |=> prdata[DIST_W-1:0] == $past(pwdata[DIST_W-1:0]))
        else $error("max_distance readback mismatch");

endmodule

bind hex_distance_map_updater hdmu_checker u_hdmu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);
`default_nettype wire
